// ----- rtl/mbrf_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrf_pkg
// Types and constants shared by the multi-byte ring FIFO and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrf_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int MAX_BYTES  = 8;
  localparam int LANES      = 8;
  localparam int LANE_W     = 3;
  localparam int LEN_W      = 4;
  localparam int DATA_W     = 64;
  localparam int FILL_W     = 10;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data_in;
  } mbrf_req_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [FILL_W-1:0] fill_count;
  } mbrf_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_POP_WAIT,
    ST_DONE
  } mbrf_state_t;

endpackage

`default_nettype wire

// ----- rtl/multi_byte_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_byte_ring_fifo
// Byte ring FIFO with all-or-nothing push and pop of up to eight bytes.
// ----------------------------------------------------------------------------
// a push steps through PUSH for its bytes then DONE, a pop through POP, POP_WAIT,
//   DONE; a refused or zero-length transfer goes straight to DONE; busy is high
//   until done ends, and no new transfer is taken while busy; the byte-wide
//   ram moves one byte per cycle and its registered read adds POP_WAIT to pops
// reset: pointers cleared (empty), ram contents left as they are
// done strobes one cycle and the receiver cannot stall it
`default_nettype none

module multi_byte_ring_fifo
  import mbrf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire mbrf_req_t req,
  output logic           busy,
  output logic           done,
  output mbrf_rsp_t      rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
  localparam logic [AW:0]   LAST_X  = (AW+1)'(DEPTH - 1);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  mbrf_state_t state, state_next;

  logic [AW-1:0]     wp, rp;
  logic              cmd_r;
  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] data_r;
  logic              ok_r;
  logic [DATA_W-1:0] dout;
  logic [LANE_W-1:0] idx;
  logic [LANE_W-1:0] rd_lane;
  logic              rd_valid;

  logic              accept;
  logic [AW:0]       diff, diff_wrap;
  logic [AW-1:0]     fill;
  logic [AW+FILL_W-1:0] fill_wide;
  logic [AW:0]       sum_push;
  logic              len_ok, fits_push, fits_pop, accept_ok, do_move;
  logic              last_lane;
  logic [AW-1:0]     wp_inc, rp_inc;

  logic              ram_we, ram_re;
  logic [7:0]        ram_rdata;

  assign accept = start && !busy;

  // fill = (wp - rp) mod depth
  assign diff      = {1'b0, wp} - {1'b0, rp};
  assign diff_wrap = diff + DEPTH_X;
  assign fill      = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
  assign fill_wide = {{FILL_W{1'b0}}, fill};

  assign sum_push  = {1'b0, fill} + (AW+1)'(req.length);
  assign len_ok    = req.length <= LEN_W'(MAX_BYTES);
  assign fits_push = sum_push <= LAST_X;
  assign fits_pop  = fill >= AW'(req.length);
  assign accept_ok = len_ok && ((req.cmd == CMD_PUSH) ? fits_push : fits_pop);
  assign do_move   = accept_ok && (req.length != '0);

  assign last_lane = ({1'b0, idx} == (len_r - LEN_W'(1)));
  assign wp_inc    = (wp == LAST_A) ? '0 : wp + AW'(1);
  assign rp_inc    = (rp == LAST_A) ? '0 : rp + AW'(1);

  mbrf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (data_r[7:0]),
    .re    (ram_re),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!do_move) begin
            state_next = ST_DONE;
          end else if (req.cmd == CMD_PUSH) begin
            state_next = ST_PUSH;
          end else begin
            state_next = ST_POP;
          end
        end
      end
      ST_PUSH: begin
        if (last_lane) begin
          state_next = ST_DONE;
        end
      end
      ST_POP: begin
        if (last_lane) begin
          state_next = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state != ST_IDLE);
    done            = (state == ST_DONE);
    ram_we          = (state == ST_PUSH);
    ram_re          = (state == ST_POP);
    rsp.ok          = ok_r;
    rsp.data_out    = dout;
    rsp.fill_count  = fill_wide[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wp       <= '0;
      rp       <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= ram_re;
      if (state == ST_PUSH) begin
        wp <= wp_inc;
      end
      if (state == ST_POP) begin
        rp <= rp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      cmd_r  <= req.cmd;
      len_r  <= req.length;
      data_r <= req.data_in;
      ok_r   <= accept_ok;
      dout   <= '0;
      idx    <= '0;
    end else begin
      if (state == ST_PUSH) begin
        // next byte moves down to lane 0
        data_r <= data_r >> 8;
        idx    <= idx + LANE_W'(1);
      end
      if (state == ST_POP) begin
        idx <= idx + LANE_W'(1);
      end
      if (rd_valid) begin
        dout[rd_lane*8 +: 8] <= ram_rdata;
      end
    end
    if (ram_re) begin
      rd_lane <= idx;
    end
  end

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transfer did not occupy the block");

  a_no_data_on_push: assert property (@(posedge clk) disable iff (rst)
    done && (!rsp.ok || cmd_r == CMD_PUSH) |-> rsp.data_out == '0)
    else $error("data returned for push or refused pop");

  a_wp_quiet_on_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP || state == ST_POP_WAIT) |-> $stable(wp))
    else $error("write pointer moved during pop");

  a_read_follows_pop: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == ST_POP)
    else $error("read data captured without a pop read");

endmodule

`default_nettype wire

// ----- rtl/mbrf_ram.sv -----
// ----------------------------------------------------------------------------
// mbrf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- test/multi_byte_ring_fifo_tb.sv -----
// ----------------------------------------------------------------------------
// multi_byte_ring_fifo_tb
// Self-checking bench for the multi-byte ring FIFO: a directed opening pass
// over empty, zero-length, over-length and refused transfers, then random
// push/pop phases that fill the ring to full, drain it to empty and wrap both
// pointers. Each transfer is predicted and checked field by field.
// ----------------------------------------------------------------------------

module multi_byte_ring_fifo_tb;
  import mbrf_pkg::*;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    mbrf_req_t req;
    int        gap;
    bit        drain;
  } queued_req_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  mbrf_req_t req   = '0;
  logic      busy;
  logic      done;
  mbrf_rsp_t rsp;

  queued_req_t queued_req[$];
  mbrf_rsp_t   pending_rsp[$];

  // predicted ring contents and pointers
  logic [7:0] ring_bytes [DEPTH];
  int         ring_wr   = 0;
  int         ring_rd   = 0;

  int idle_cnt  = 0;
  int cycle_cnt = 0;
  int errors    = 0;
  bit took      = 1'b0;

  multi_byte_ring_fifo #(
    .DEPTH(DEPTH)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic mbrf_rsp_t ring_transfer(input mbrf_req_t r);
    mbrf_rsp_t o;
    int        fill;
    int        n;
    int        i;
    o    = '0;
    n    = int'(r.length);
    fill = (ring_wr - ring_rd + DEPTH) % DEPTH;
    if (n <= MAX_BYTES) begin
      if (r.cmd == CMD_PUSH) begin
        if (DEPTH - 1 - fill >= n) begin
          for (i = 0; i < n; i++) ring_bytes[(ring_wr + i) % DEPTH] = r.data_in[8*i +: 8];
          ring_wr = (ring_wr + n) % DEPTH;
          o.ok    = 1'b1;
        end
      end else begin
        if (fill >= n) begin
          for (i = 0; i < n; i++) o.data_out[8*i +: 8] = ring_bytes[(ring_rd + i) % DEPTH];
          ring_rd = (ring_rd + n) % DEPTH;
          o.ok    = 1'b1;
        end
      end
    end
    o.fill_count = FILL_W'((ring_wr - ring_rd + DEPTH) % DEPTH);
    return o;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("%s", msg);
  endtask

  task automatic add_req(input logic cmd, input int len, input logic [DATA_W-1:0] data,
                         input int gap, input bit drain);
    queued_req_t q;
    q.req.cmd     = cmd;
    q.req.length  = LEN_W'(len);
    q.req.data_in = data;
    q.gap         = gap;
    q.drain       = drain;
    queued_req.push_back(q);
  endtask

  // mostly legal lengths, some zero, some above the lane count
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 90) return $urandom_range(1, MAX_BYTES);
    return $urandom_range(MAX_BYTES + 1, 15);
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: one nonblocking update of start and req per falling edge
  always @(negedge clk) begin
    logic        nxt_start;
    mbrf_req_t   nxt_req;
    queued_req_t nxt;
    nxt_start = start;
    nxt_req   = req;
    if (!rst) begin
      if (start && took) begin
        nxt_start = 1'b0;
        idle_cnt  = (queued_req.size() != 0) ? queued_req[0].gap : 0;
      end
      if (!nxt_start && queued_req.size() != 0) begin
        if (idle_cnt > 0) begin
          idle_cnt--;
        end else if (!queued_req[0].drain || pending_rsp.size() == 0) begin
          nxt       = queued_req.pop_front();
          nxt_start = 1'b1;
          nxt_req   = nxt.req;
        end
      end
    end
    start <= nxt_start;
    req   <= nxt_req;
  end

  // monitor: results first, then the transfer accepted at this edge
  always @(posedge clk) begin
    mbrf_rsp_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      took = 1'b0;
      if (!rst) begin
        if (done) begin
          if (pending_rsp.size() == 0) begin
            note_error($sformatf("unexpected result: ok=%0d data=%h fill=%0d",
                                 rsp.ok, rsp.data_out, rsp.fill_count));
          end else begin
            want = pending_rsp.pop_front();
            if (rsp.ok !== want.ok || rsp.data_out !== want.data_out ||
                rsp.fill_count !== want.fill_count)
              note_error($sformatf("result mismatch: expected ok=%0d data=%h fill=%0d, got ok=%0d data=%h fill=%0d",
                                   want.ok, want.data_out, want.fill_count,
                                   rsp.ok, rsp.data_out, rsp.fill_count));
          end
        end
        if (start && !busy) begin
          took = 1'b1;
          pending_rsp.push_back(ring_transfer(req));
        end
      end
    end
  end

  initial begin
    int seg;
    int k;
    int push_pct;
    int seg_items;
    bit burst;
    bit is_pop;

    // opening pass: empty ring, zero and over-long lengths, refusals
    add_req(CMD_POP,  1,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 0,  {$urandom, $urandom},    pick_gap(0), 1'b0);
    add_req(CMD_POP,  0,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 8,  '1,                      pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 8,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 1,  64'hffff_ffff_ffff_ffa5, pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 9,  {$urandom, $urandom},    pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 15, '1,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  15, '1,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  8,  '0,                      pick_gap(0), 1'b1);
    add_req(CMD_POP,  8,  '1,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  2,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  1,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 3,  {$urandom, $urandom},    pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 5,  {$urandom, $urandom},    pick_gap(0), 1'b0);
    add_req(CMD_POP,  4,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  0,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  4,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  1,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 8,  64'h0123_4567_89ab_cdef, pick_gap(0), 1'b1);
    add_req(CMD_POP,  8,  '0,                      pick_gap(0), 1'b0);
    add_req(CMD_PUSH, 1,  '1,                      pick_gap(0), 1'b0);
    add_req(CMD_POP,  1,  '0,                      pick_gap(0), 1'b1);

    // random phases swing the fill between empty and full so both pointers wrap
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin push_pct = 90; seg_items = 400; end
        1: begin push_pct = 50; seg_items = 150; end
        2: begin push_pct = 10; seg_items = 300; end
        3: begin push_pct = 50; seg_items = 100; end
        4: begin push_pct = 85; seg_items = 200; end
        default: begin push_pct = 15; seg_items = 100; end
      endcase
      burst = 1'b0;
      for (k = 0; k < seg_items; k++) begin
        if (k % 40 == 0) burst = ($urandom_range(0, 2) == 0);
        is_pop = ($urandom_range(1, 100) > push_pct);
        add_req(is_pop ? CMD_POP : CMD_PUSH, rand_len(), {$urandom, $urandom},
                pick_gap(burst), k == 0);
      end
    end

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    while (queued_req.size() != 0 || start) @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
